### hw/rtl/preorder_bst_check_core_macros.svh
// assertion macros for the preorder bst check core
`ifndef PREORDER_BST_CHECK_CORE_MACROS_SVH
`define PREORDER_BST_CHECK_CORE_MACROS_SVH
`ifndef SYNTHESIS
// condition and consequence in the same cycle
`define PBC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pbc assertion failed");
// consequence in the cycle after the condition
`define PBC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pbc assertion failed");
`else
`define PBC_ASSERT_NOW(lbl, ante, cons)
`define PBC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### hw/rtl/pbc_pkg.sv
// shared types for the preorder bst check core
package pbc_pkg;

	localparam int unsigned ELEM_W = 32;

	typedef struct packed {
		logic signed [ELEM_W-1:0] element_value;
		logic                     first_element;
		logic                     last_element;
	} in_item_t;

	typedef struct packed {
		logic sequence_ok;
		logic stack_overflow;
		logic end_of_sequence;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_REFILL
	} state_t;

	// status from the datapath to the sequencer
	typedef struct packed {
		logic in_valid;
		logic pop_cond;
		logic out_free;
	} stat_t;

	// decoded sequencer controls
	typedef struct packed {
		logic in_ready;
		logic do_pop;
		logic do_refill;
		logic do_finish;
	} ctrl_t;

endpackage

### hw/rtl/pbc_stack_mem.sv
// stack storage, one write and one registered read port
module pbc_stack_mem #(
	parameter int unsigned DEPTH = 128,
	parameter int unsigned WIDTH = 32,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### hw/rtl/pbc_seq.sv
// sequencer: accept, pop scan, refill and result post
module pbc_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  pbc_pkg::stat_t  stat,
	output pbc_pkg::ctrl_t  ctrl
);

	pbc_pkg::state_t state_q;
	pbc_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pbc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			pbc_pkg::ST_IDLE: begin
				if (stat.in_valid) begin
					state_d = pbc_pkg::ST_SCAN;
				end
			end
			pbc_pkg::ST_SCAN: begin
				if (stat.pop_cond) begin
					state_d = pbc_pkg::ST_REFILL;
				end else if (stat.out_free) begin
					state_d = pbc_pkg::ST_IDLE;
				end
			end
			pbc_pkg::ST_REFILL: begin
				state_d = pbc_pkg::ST_SCAN;
			end
			default: begin
				state_d = pbc_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ctrl = '0;
		case (state_q)
			pbc_pkg::ST_IDLE: begin
				ctrl.in_ready = 1'b1;
			end
			pbc_pkg::ST_SCAN: begin
				ctrl.do_pop    = stat.pop_cond;
				ctrl.do_finish = !stat.pop_cond && stat.out_free;
			end
			pbc_pkg::ST_REFILL: begin
				ctrl.do_refill = 1'b1;
			end
			default: begin
				ctrl = '0;
			end
		endcase
	end

endmodule

### hw/rtl/preorder_bst_check_core.sv
// top level of the preorder bst check core
//
// checks whether a stream of signed values can be the preorder walk of a
// binary search tree, giving one verdict per value
// - input channel in_valid / in_ready / in_item: one request per value;
//   first_element clears stack, bound and flags before the value is used
// - output channel out_valid / out_ready / out_item: one result per request,
//   with the running verdict, the sticky overflow flag and an echo of last_element
// - the top of stack lives in a register, the entries below it in a
//   single-port-write memory with a registered read
// - each popped value passes the scan state, where it is compared and popped,
//   then the refill state, where the memory read reloads the top-of-stack register
// - the result register loads once every pop for a request is done, and the
//   next request can be taken once the sequencer is back in the idle state
// - a new request is taken as soon as the sequencer is idle, even while the
//   previous result still waits; on a receiver stall the finishing request
//   holds in the scan state until the output register frees up
// - reset clears the stack count, bound, flags and sequencer; the memory is
//   not cleared, as entries above the count are never read
`include "preorder_bst_check_core_macros.svh"

module preorder_bst_check_core #(
	parameter int unsigned STACK_DEPTH = 128,
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  pbc_pkg::in_item_t   in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output pbc_pkg::out_item_t  out_item
);

	localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

	pbc_pkg::stat_t stat;
	pbc_pkg::ctrl_t ctrl;

	// value under test and sticky sequence state
	logic signed [VALUE_WIDTH-1:0] val_q;
	logic                          last_q;
	logic signed [VALUE_WIDTH-1:0] tos_q;
	logic signed [VALUE_WIDTH-1:0] bound_q;
	logic                          bound_set_q;
	logic                          viol_q;
	logic                          ovf_q;
	logic [CW-1:0]                 count_q;

	// result register
	pbc_pkg::out_item_t out_q;
	logic               out_valid_q;

	logic [63:0]                   elem_ext;
	logic signed [VALUE_WIDTH-1:0] val_in;
	logic                          accept;
	logic                          first_in;
	logic                          bound_hit;
	logic                          more_below;
	logic                          stack_full;
	logic                          mem_wr_en;
	logic                          mem_rd_en;
	logic [AW-1:0]                 mem_wr_addr;
	logic [AW-1:0]                 mem_rd_addr;
	logic [CW-1:0]                 count_m1;
	logic [CW-1:0]                 count_m2;
	logic [VALUE_WIDTH-1:0]        mem_rd_data;

	// sign-extend the field, then keep the low value bits
	assign elem_ext = {{(64 - pbc_pkg::ELEM_W){in_item.element_value[pbc_pkg::ELEM_W-1]}},
		in_item.element_value};
	assign val_in   = elem_ext[VALUE_WIDTH-1:0];
	assign accept   = in_valid && ctrl.in_ready;
	assign first_in = in_item.first_element;

	// bound check on the state as it stands before any pop
	assign bound_hit = !first_in && bound_set_q && (val_in < bound_q);

	assign count_m1   = count_q - CW'(1);
	assign count_m2   = count_q - CW'(2);
	assign more_below = count_q > CW'(1);
	assign stack_full = count_q == CW'(STACK_DEPTH);

	assign stat.in_valid = in_valid;
	assign stat.pop_cond = (count_q != '0) && (tos_q < val_q);
	assign stat.out_free = !out_valid_q || out_ready;

	// a pop with entries left below fetches the new top of stack
	assign mem_rd_en   = ctrl.do_pop && more_below;
	assign mem_rd_addr = count_m2[AW-1:0];
	// a push spills the old top of stack into the memory
	assign mem_wr_en   = ctrl.do_finish && !stack_full && (count_q != '0);
	assign mem_wr_addr = count_m1[AW-1:0];

	pbc_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	pbc_stack_mem #(
		.DEPTH (STACK_DEPTH),
		.WIDTH (VALUE_WIDTH)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (tos_q),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			val_q  <= val_in;
			last_q <= in_item.last_element;
		end
		if (ctrl.do_refill) begin
			tos_q <= mem_rd_data;
		end else if (ctrl.do_finish && !stack_full) begin
			tos_q <= val_q;
		end
		if (ctrl.do_finish) begin
			out_q.sequence_ok     <= !viol_q;
			out_q.stack_overflow  <= ovf_q || stack_full;
			out_q.end_of_sequence <= last_q;
		end
	end

	// sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			bound_q     <= '0;
			bound_set_q <= 1'b0;
			viol_q      <= 1'b0;
			ovf_q       <= 1'b0;
		end else if (accept) begin
			if (first_in) begin
				count_q     <= '0;
				bound_q     <= '0;
				bound_set_q <= 1'b0;
				ovf_q       <= 1'b0;
				viol_q      <= 1'b0;
			end else begin
				viol_q <= viol_q || bound_hit;
			end
		end else if (ctrl.do_pop) begin
			bound_q     <= tos_q;
			bound_set_q <= 1'b1;
			count_q     <= count_m1;
		end else if (ctrl.do_finish) begin
			if (stack_full) begin
				ovf_q <= 1'b1;
			end else begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	// output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.do_finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = ctrl.in_ready;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// stack count never passes the depth
	`PBC_ASSERT_NOW(a_count_range, 1'b1, count_q <= CW'(STACK_DEPTH))
	// a pop moves the old top of stack into the bound
	`PBC_ASSERT_NEXT(a_pop_bound, ctrl.do_pop, bound_set_q && (bound_q == $past(tos_q)))
	// a pop with entries left is always followed by a refill
	`PBC_ASSERT_NEXT(a_pop_refill, ctrl.do_pop && more_below, ctrl.do_refill)

endmodule
